// File: hdl/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg: shared types and constants of the tick service monitor
// Holds command codes, slot codes, widths and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package tsm_pkg;

  localparam int unsigned HistDepth = 1024;
  localparam int unsigned HistAw    = $clog2(HistDepth);
  localparam int unsigned Tracked   = 8;
  localparam int unsigned FillMax   = 255;
  localparam int unsigned TpmReset  = 1000;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CODE_VAL   = 2'd0,
    CODE_BUSY  = 2'd1,
    CODE_WRONG = 2'd2,
    CODE_HELD  = 2'd3
  } slot_e;

  // classified transaction passed from front to back
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] timer_now;
    logic [31:0] now_ms;
    logic [3:0]  okc;
    logic [3:0]  bsc;
    logic [3:0]  nfc;
    logic [3:0]  bdc;
    slot_e       slot;
  } item_t;

  typedef struct packed {
    slot_e       slot_code;
    logic [31:0] late_ticks;
    logic [31:0] blocked_total;
    logic [31:0] latency_max;
    logic [31:0] no_value_total;
    logic [31:0] gap_run;
    logic [31:0] gap_max;
    logic [31:0] served_total;
    logic [31:0] ok_total;
    logic [31:0] busy_total;
    logic [31:0] not_found_total;
    logic [31:0] bad_total;
  } result_t;

  function automatic logic [3:0] clamp_cnt(input logic [3:0] c);
    clamp_cnt = (c > 4'(Tracked)) ? 4'(Tracked) : c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/tsm_front.sv
// ----------------------------------------------------------------------------
// tsm_front: input stage of the tick service monitor
// Accepts transactions, saturates counts, classifies the tick and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_front import tsm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] timer_now_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [3:0]  ok_count_i,
  input  wire logic [3:0]  busy_count_i,
  input  wire logic [3:0]  not_found_count_i,
  input  wire logic [3:0]  bad_count_i,
  output logic             q_valid_o,
  output item_t            q_item_o,
  input  wire logic        q_pop_i
);

  localparam int unsigned QDepth = 2;

  item_t       mem_q [QDepth];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  item_t       item;
  logic        push;

  // classify the incoming tick
  always_comb begin
    item.cmd       = cmd_e'(command_i);
    item.timer_now = timer_now_i;
    item.now_ms    = now_ms_i;
    item.okc       = clamp_cnt(ok_count_i);
    item.bsc       = clamp_cnt(busy_count_i);
    item.nfc       = clamp_cnt(not_found_count_i);
    item.bdc       = clamp_cnt(bad_count_i);
    if (item.nfc != 4'd0 || item.bdc != 4'd0) item.slot = CODE_WRONG;
    else if (item.bsc != 4'd0)                item.slot = CODE_BUSY;
    else                                      item.slot = CODE_VAL;
  end

  assign in_stall  = (cnt_q == 2'(QDepth));
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rd_q];

  // hold queue entries
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item;
  end

  // advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

`default_nettype wire

// File: hdl/tsm_back.sv
// ----------------------------------------------------------------------------
// tsm_back: execution stage of the tick service monitor
// Runs lateness, serial division, held marking, statistics and history reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_back import tsm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [19:0] tpm_i,
  input  wire logic        q_valid_i,
  input  item_t            q_item_i,
  output logic             q_pop_o,
  output logic             out_valid,
  input  wire logic        out_stall,
  output result_t          res_o
);

  localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_MUL = 3'd2,
                         S_FILL = 3'd3, S_FIN = 3'd4, S_RD = 3'd5, S_RD2 = 3'd6;

  logic [2:0]  st_q;
  item_t       it_q;
  logic [31:0] lat_q, rem_q, quo_q, ref_q, period_q;
  logic [5:0]  bit_q;
  logic [7:0]  fill_q;
  logic [31:0] blk_q, peak_q, srv_q, okt_q, bst_q, nft_q, bdt_q, nov_q, run_q, rmax_q;
  logic [HistAw-1:0] clr_q;
  logic        clr_done_q;
  logic [1:0]  hist_q [HistDepth];
  logic [1:0]  rdat_q;
  logic        ov_q;
  result_t     res_q;
  logic [32:0] trial;
  logic [31:0] run_n, nov_n, rmax_n, lat_n;

  assign q_pop_o   = (st_q == S_IDLE) && q_valid_i && !ov_q && clr_done_q;
  assign out_valid = ov_q;
  assign res_o     = res_q;
  assign trial     = {rem_q[31:0], lat_q[31 - bit_q[4:0]]} ;
  assign lat_n     = q_item_i.timer_now - ref_q;

  // history memory: held marks, tick slot and reset clear
  always_ff @(posedge clk_i) begin
    if (!clr_done_q) hist_q[clr_q] <= CODE_VAL;
    else if (st_q == S_FILL) hist_q[HistAw'(it_q.now_ms - 32'(fill_q))] <= CODE_HELD;
    else if (st_q == S_FIN && it_q.cmd == CMD_TICK)
      hist_q[it_q.now_ms[HistAw-1:0]] <= it_q.slot;
    rdat_q <= hist_q[it_q.now_ms[HistAw-1:0]];
  end

  // final stale counters of a tick
  always_comb begin
    nov_n  = nov_q;
    run_n  = run_q;
    rmax_n = rmax_q;
    if (it_q.slot == CODE_VAL) run_n = 32'd0;
    else begin
      nov_n = nov_q + 32'd1;
      run_n = run_q + 32'd1;
    end
    if (run_n > rmax_n) rmax_n = run_n;
  end

  // sequence one transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ov_q <= 1'b0; ref_q <= '0;
      clr_q <= '0; clr_done_q <= 1'b0;
      blk_q <= '0; peak_q <= '0; srv_q <= '0; okt_q <= '0; bst_q <= '0;
      nft_q <= '0; bdt_q <= '0; nov_q <= '0; run_q <= '0; rmax_q <= '0;
      lat_q <= '0; rem_q <= '0; quo_q <= '0; period_q <= '0; bit_q <= '0;
      fill_q <= '0; it_q <= '0; res_q <= '0;
    end else begin
      if (ov_q && !out_stall) ov_q <= 1'b0;
      if (!clr_done_q) begin
        clr_q <= clr_q + 1'b1;
        if (&clr_q) clr_done_q <= 1'b1;
      end
      case (st_q)
        S_IDLE: begin
          if (q_pop_o) begin
            it_q <= q_item_i;
            case (q_item_i.cmd)
              CMD_TICK: begin
                lat_q    <= lat_n[31] ? 32'd0 : lat_n;
                period_q <= (tpm_i == 20'd0) ? 32'd1 : 32'(tpm_i);
                rem_q    <= '0;
                quo_q    <= '0;
                bit_q    <= '0;
                st_q     <= S_DIV;
              end
              CMD_CLEAR: begin
                blk_q <= '0; peak_q <= '0; srv_q <= '0; okt_q <= '0; bst_q <= '0;
                nft_q <= '0; bdt_q <= '0; nov_q <= '0; run_q <= '0; rmax_q <= '0;
                st_q  <= S_FIN;
              end
              CMD_READ: st_q <= S_RD;
              default:  st_q <= S_FIN;
            endcase
          end
        end
        // restoring division, one quotient bit per cycle
        S_DIV: begin
          if (trial >= {1'b0, period_q}) begin
            rem_q <= 32'(trial - {1'b0, period_q});
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= trial[31:0];
            quo_q <= {quo_q[30:0], 1'b0};
          end
          bit_q <= bit_q + 6'd1;
          if (bit_q == 6'd31) st_q <= S_MUL;
        end
        S_MUL: begin
          ref_q  <= ref_q + period_q * (quo_q + 32'd1);
          fill_q <= (quo_q > 32'(FillMax)) ? 8'(FillMax) : quo_q[7:0];
          if (quo_q != 32'd0) begin
            blk_q <= blk_q + quo_q;
            nov_q <= nov_q + quo_q;
            run_q <= run_q + quo_q;
            if (run_q + quo_q > rmax_q) rmax_q <= run_q + quo_q;
            st_q  <= S_FILL;
          end else st_q <= S_FIN;
        end
        // mark earlier entries held, highest offset first
        S_FILL: begin
          fill_q <= fill_q - 8'd1;
          if (fill_q == 8'd1) st_q <= S_FIN;
        end
        S_RD:  st_q <= S_RD2;
        S_RD2: st_q <= S_FIN;
        S_FIN: begin
          if (!ov_q || !out_stall) begin
            if (it_q.cmd == CMD_TICK) begin
              srv_q  <= srv_q + 32'd1;
              okt_q  <= okt_q + 32'(it_q.okc);
              bst_q  <= bst_q + 32'(it_q.bsc);
              nft_q  <= nft_q + 32'(it_q.nfc);
              bdt_q  <= bdt_q + 32'(it_q.bdc);
              nov_q  <= nov_n; run_q <= run_n; rmax_q <= rmax_n;
              if (lat_q > peak_q) peak_q <= lat_q;
              res_q <= '{slot_code: it_q.slot, late_ticks: lat_q,
                blocked_total: blk_q, latency_max: (lat_q > peak_q) ? lat_q : peak_q,
                no_value_total: nov_n, gap_run: run_n, gap_max: rmax_n,
                served_total: srv_q + 32'd1, ok_total: okt_q + 32'(it_q.okc),
                busy_total: bst_q + 32'(it_q.bsc), not_found_total: nft_q + 32'(it_q.nfc),
                bad_total: bdt_q + 32'(it_q.bdc)};
            end else begin
              res_q <= '{slot_code: (it_q.cmd == CMD_READ) ? slot_e'(rdat_q) : CODE_VAL,
                late_ticks: 32'd0, blocked_total: blk_q, latency_max: peak_q,
                no_value_total: nov_q, gap_run: run_q, gap_max: rmax_q,
                served_total: srv_q, ok_total: okt_q, busy_total: bst_q,
                not_found_total: nft_q, bad_total: bdt_q};
            end
            ov_q <= 1'b1;
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/tick_service_monitor_top.sv
// ----------------------------------------------------------------------------
// tick_service_monitor_top: one-millisecond service tick monitor
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | command .. bad_count
//   out     | output    | out_valid/out_stall| slot_code .. bad_total
//   cfg     | input     | cfg_valid/cfg_ready| period_cnt
//
// A tick runs the lateness divider, which produces one quotient bit per cycle,
// then marks each held history entry (up to 255). Clear and other commands
// finish directly; a history read passes a registered memory read first.
// After reset a clearing pass sweeps all 1024 history entries; no
// transaction starts before it ends. A two-entry queue decouples input from
// execution, and the output register holds a result while out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_service_monitor_top import tsm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [19:0] period_cnt_i,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] timer_now_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [3:0]  ok_count_i,
  input  wire logic [3:0]  busy_count_i,
  input  wire logic [3:0]  not_found_count_i,
  input  wire logic [3:0]  bad_count_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       slot_code_o,
  output logic [31:0]      late_ticks_o,
  output logic [31:0]      blocked_total_o,
  output logic [31:0]      latency_max_o,
  output logic [31:0]      no_value_total_o,
  output logic [31:0]      gap_run_o,
  output logic [31:0]      gap_max_o,
  output logic [31:0]      served_total_o,
  output logic [31:0]      ok_total_o,
  output logic [31:0]      busy_total_o,
  output logic [31:0]      not_found_total_o,
  output logic [31:0]      bad_total_o
);

  logic [19:0] tpm_q;
  logic        q_valid, q_pop;
  item_t       q_item;
  result_t     res;

  assign cfg_ready = 1'b1;

  // hold the tick period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tpm_q <= 20'(TpmReset);
    else if (cfg_valid) tpm_q <= period_cnt_i;
  end

  tsm_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .command_i, .timer_now_i, .now_ms_i,
    .ok_count_i, .busy_count_i, .not_found_count_i, .bad_count_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  tsm_back u_back (
    .clk_i, .rst_ni, .tpm_i(tpm_q), .q_valid_i(q_valid), .q_item_i(q_item),
    .q_pop_o(q_pop), .out_valid, .out_stall, .res_o(res)
  );

  assign slot_code_o       = res.slot_code;
  assign late_ticks_o      = res.late_ticks;
  assign blocked_total_o   = res.blocked_total;
  assign latency_max_o     = res.latency_max;
  assign no_value_total_o  = res.no_value_total;
  assign gap_run_o         = res.gap_run;
  assign gap_max_o         = res.gap_max;
  assign served_total_o    = res.served_total;
  assign ok_total_o        = res.ok_total;
  assign busy_total_o      = res.busy_total;
  assign not_found_total_o = res.not_found_total;
  assign bad_total_o       = res.bad_total;

endmodule

`default_nettype wire

// File: hdl/tsm_checker.sv
// ----------------------------------------------------------------------------
// tsm_checker: port-level checks of the tick service monitor
// Watches the output channel and the statistics it reports.
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_checker import tsm_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  slot_code_o,
  input wire logic [31:0] late_ticks_o,
  input wire logic [31:0] latency_max_o,
  input wire logic [31:0] gap_run_o,
  input wire logic [31:0] gap_max_o
);

  // a stalled result stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(slot_code_o))
    else $error("stalled result changed");

  // peak lateness covers this transaction's lateness
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> latency_max_o >= late_ticks_o)
    else $error("latency max below lateness");

  // longest stale run covers the current one
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> gap_max_o >= gap_run_o)
    else $error("stale max below run");

  // a tick with nonzero lateness never reports the held code
  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && late_ticks_o != 32'd0 |-> slot_code_o != CODE_HELD)
    else $error("tick classified as held");

endmodule

bind tick_service_monitor_top tsm_checker u_tsm_checker (
  .clk_i, .rst_ni, .out_valid, .out_stall, .slot_code_o, .late_ticks_o,
  .latency_max_o, .gap_run_o, .gap_max_o
);

`default_nettype wire

// File: bench/tick_service_monitor_top_test.sv
// ----------------------------------------------------------------------------
// tick_service_monitor_top_test: self-checking bench for the tick monitor
// Drives ticks, clears, history reads and unused commands with random gaps
// on both sides, predicts every result with a local model of the monitor
// and compares each returned transaction field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_service_monitor_top_test import tsm_pkg::*;;

  // one returned transaction
  typedef struct {
    logic [1:0]  slot;
    logic [31:0] late;
    logic [31:0] stat [10];
  } tick_report_t;

  // tracks monitor state and the queue of predicted reports
  class tick_scoreboard;
    logic [19:0] period_cfg;
    logic [31:0] ref_count;
    logic [1:0]  hist [HistDepth];
    logic [31:0] stat [10];
    tick_report_t pending [$];
    int errors;

    function void reset_state();
      period_cfg = 20'(TpmReset);
      ref_count  = '0;
      foreach (hist[i]) hist[i] = CODE_VAL;
      foreach (stat[i]) stat[i] = '0;
      pending.delete();
      errors = 0;
    endfunction

    function logic [31:0] sat(logic [3:0] c);
      return (c > 4'(Tracked)) ? 32'(Tracked) : 32'(c);
    endfunction

    // stat order: blocked, lat max, no value, run, run max, served, ok, busy, nf, bad
    function void note_input(cmd_e cmd, logic [31:0] tnow, logic [31:0] nms,
                             logic [3:0] ok, logic [3:0] bs, logic [3:0] nf,
                             logic [3:0] bd);
      tick_report_t r;
      logic [31:0] per, lat, missed, fill;
      logic [1:0] cls;
      r.slot = CODE_VAL;
      r.late = '0;
      if (cmd == CMD_TICK) begin
        per = (period_cfg == 0) ? 32'd1 : 32'(period_cfg);
        lat = tnow - ref_count;
        if (lat[31]) lat = '0;
        missed = lat / per;
        ref_count = ref_count + per * (32'd1 + missed);
        if (missed != 0) begin
          fill = (missed > FillMax) ? FillMax : missed;
          stat[0] += missed;
          for (int k = 1; k <= fill; k++) hist[(nms - k) % HistDepth] = CODE_HELD;
          stat[2] += missed;
          stat[3] += missed;
          if (stat[3] > stat[4]) stat[4] = stat[3];
        end
        if (lat > stat[1]) stat[1] = lat;
        stat[5]++;
        stat[6] += sat(ok);
        stat[7] += sat(bs);
        stat[8] += sat(nf);
        stat[9] += sat(bd);
        if (sat(nf) != 0 || sat(bd) != 0) cls = CODE_WRONG;
        else if (sat(bs) != 0) cls = CODE_BUSY;
        else cls = CODE_VAL;
        hist[nms % HistDepth] = cls;
        if (cls == CODE_VAL) stat[3] = '0;
        else begin
          stat[2]++;
          stat[3]++;
        end
        if (stat[3] > stat[4]) stat[4] = stat[3];
        r.slot = cls;
        r.late = lat;
      end else if (cmd == CMD_CLEAR) begin
        foreach (stat[i]) stat[i] = '0;
      end else if (cmd == CMD_READ) begin
        r.slot = hist[nms % HistDepth];
      end
      r.stat = stat;
      pending.push_back(r);
    endfunction

    task check_result(tick_report_t got);
      tick_report_t w;
      if (pending.size() == 0) begin
        report("result with nothing pending", 0, 0);
        return;
      end
      w = pending.pop_front();
      if (got.slot !== w.slot) report("slot_code", got.slot, w.slot);
      if (got.late !== w.late) report("late_ticks", got.late, w.late);
      foreach (w.stat[i])
        if (got.stat[i] !== w.stat[i]) report($sformatf("statistic %0d", i),
                                              got.stat[i], w.stat[i]);
    endtask

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [19:0] period_cnt_i = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command_i = '0;
  logic [31:0] timer_now_i = '0, now_ms_i = '0;
  logic [3:0] ok_count_i = '0, busy_count_i = '0, not_found_count_i = '0, bad_count_i = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [1:0] slot_code_o;
  logic [31:0] late_ticks_o, blocked_total_o, latency_max_o, no_value_total_o;
  logic [31:0] gap_run_o, gap_max_o, served_total_o, ok_total_o;
  logic [31:0] busy_total_o, not_found_total_o, bad_total_o;

  tick_service_monitor_top dut (.*);

  tick_scoreboard sb = new();
  longint cycles = 0;
  bit stall_idle = 1'b0;
  logic [31:0] ms_base = '0;

  always #10 clk_i = ~clk_i;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // stall the output side at random, or hold it open
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (!rst_ni) out_stall <= 1'b1;
    else if (stall_idle) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 30);
  end

  // compare each accepted result
  always @(posedge clk_i) begin
    tick_report_t g;
    if (rst_ni && out_valid && !out_stall) begin
      g.slot = slot_code_o;
      g.late = late_ticks_o;
      g.stat = '{blocked_total_o, latency_max_o, no_value_total_o, gap_run_o,
                 gap_max_o, served_total_o, ok_total_o, busy_total_o,
                 not_found_total_o, bad_total_o};
      sb.check_result(g);
    end
  end

  // give up on a hung run
  always @(posedge clk_i) begin
    if (cycles > 3000000) begin
      $display("tick_service_monitor_top_test: done, errors");
      $finish;
    end
  end

  task automatic send(cmd_e cmd, logic [31:0] tnow, logic [31:0] nms,
                      logic [3:0] ok, logic [3:0] bs, logic [3:0] nf, logic [3:0] bd);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    command_i <= cmd;
    timer_now_i <= tnow;
    now_ms_i <= nms;
    ok_count_i <= ok;
    busy_count_i <= bs;
    not_found_count_i <= nf;
    bad_count_i <= bd;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_input(cmd, tnow, nms, ok, bs, nf, bd);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_period(logic [19:0] v);
    cfg_valid <= 1'b1;
    period_cnt_i <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    sb.period_cfg = v;
  endtask

  // tick near the expected time, sometimes early, late by 1 to 6 or 200 to 300 periods, or random
  task automatic random_tick();
    logic [31:0] per, slip;
    int p;
    per = (sb.period_cfg == 0) ? 32'd1 : 32'(sb.period_cfg);
    p = $urandom_range(0, 99);
    if (p < 60) slip = $urandom_range(0, 32'(per) - 1);
    else if (p < 80) slip = per * $urandom_range(1, 6) + $urandom_range(0, 32'(per) - 1);
    else if (p < 88) slip = per * $urandom_range(200, 300);
    else if (p < 95) slip = -$urandom_range(1, 5000);
    else slip = $urandom();
    ms_base = ms_base + 1 + ((slip > per) ? slip / per : 0);
    send(CMD_TICK, sb.ref_count + slip, ($urandom_range(0, 9) == 0) ? $urandom() : ms_base,
         4'($urandom_range(0, 15)),
         ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd0,
         ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'd0,
         ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'd0);
  endtask

  initial begin
    logic [19:0] periods [5];
    int p;
    periods = '{20'd1, 20'hFFFFF, 20'd0, 20'd37, 20'd1000};
    sb.reset_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    stall_idle = 1'b0;

    // directed: extremes, every command, held marks wrapping below zero
    send(CMD_READ, '0, 32'd5, 0, 0, 0, 0);
    send(CMD_TICK, 32'd10, 32'd0, 4'd15, 0, 0, 0);
    send(CMD_TICK, 32'd1500, 32'd1, 0, 4'd9, 0, 0);
    send(CMD_TICK, 32'd300000, 32'd2, 0, 0, 4'd1, 0);
    send(CMD_READ, '0, 32'hFFFFFFFF, 0, 0, 0, 0);
    send(CMD_READ, '0, 32'd1023, 0, 0, 0, 0);
    send(CMD_TICK, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'd8, 4'd8, 4'd8, 4'd15);
    send(CMD_TICK, 32'h80000000, 32'h12345678, 0, 0, 0, 4'd3);
    send(CMD_TICK, 32'd0, 32'd3, 4'd1, 0, 0, 0);
    send(CMD_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'hF, 4'hF, 4'hF, 4'hF);
    send(CMD_READ, '0, 32'd2, 0, 0, 0, 0);
    send(CMD_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'hF, 4'hF, 4'hF, 4'hF);
    send(CMD_READ, '0, 32'h12345677, 0, 0, 0, 0);
    send(CMD_TICK, sb.ref_count, 32'd4, 0, 0, 0, 0);

    // hold off until everything is back, then random phases per period
    stall_idle = 1'b1;
    drain();
    stall_idle = 1'b0;
    ms_base = $urandom();
    foreach (periods[i]) begin
      write_period(periods[i]);
      repeat (380) begin
        p = $urandom_range(0, 99);
        if (p < 78) random_tick();
        else if (p < 92) send(CMD_READ, '0, ($urandom_range(0, 1)) ? ms_base - $urandom_range(0, 300)
                              : $urandom(), 0, 0, 0, 0);
        else if (p < 96) send(CMD_CLEAR, $urandom(), $urandom(), 4'($urandom()), 0, 0, 0);
        else send(cmd_e'(p[0] ? CMD_NONE : CMD_CLEAR), $urandom(), $urandom(),
                  4'($urandom()), 4'($urandom()), 4'($urandom()), 4'($urandom()));
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tick_service_monitor_top_test: done, clean");
    else
      $display("tick_service_monitor_top_test: done, errors");
    $finish;
  end
endmodule

`default_nettype wire
